[src/sefs_pkg.sv]
package sefs_pkg;

   // Default sizing
   localparam int MAX_THREADS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 16;

   // Thread identifier width is fixed by the item format
   localparam int ID_BITS = 4;

   // Command opcodes
   localparam logic [1:0] OP_CREATE = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_EXIT   = 2'd2;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [ID_BITS-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] running_id;
      logic               running_valid;
      logic               queue_full;
   } rsp_type;

   // What every cell of the ready row does in an update cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_POP_INSERT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type      mode;
      logic [ID_BITS-1:0] ins_id;
   } cell_ctl_type;

endpackage

[src/shortest_elapsed_first_scheduler.sv]
// A command accepted at one edge is held in the command register and executed in
// the ready row's update cycle; the result of that cycle is registered onto rsp_* with rsp_strobe.
// A new command is taken only while busy is low: busy is high during the update
// cycle of the ready row and drops while the result is shown.
// Reset (synchronous): no thread running, ready row empty; the row's cells keep
// stale contents that are never read. The receiver cannot stall.
module shortest_elapsed_first_scheduler import sefs_pkg::*; #(
   parameter int MAX_THREADS = MAX_THREADS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int SIZE_BITS = $clog2(MAX_THREADS + 1);
   localparam logic [SIZE_BITS-1:0]  SIZE_FULL = SIZE_BITS'(MAX_THREADS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Command register: holds the item for its update cycle
   logic    pend_ff, pend_in;
   req_type cmd_ff, cmd_in;

   // Running slot
   logic                  run_valid_ff, run_valid_in;
   logic [ID_BITS-1:0]    run_id_ff, run_id_in;
   logic [COUNT_BITS-1:0] run_count_ff, run_count_in;

   // Ready row occupancy (entries 0 .. size-1 hold the sorted queue)
   logic [SIZE_BITS-1:0] size_ff, size_in;

   // Result register
   logic    rsp_strobe_ff, rsp_strobe_in;
   rsp_type rsp_ff, rsp_in;

   // Cell row
   cell_ctl_type          ctl;
   logic [COUNT_BITS-1:0] ins_cnt;
   logic                  cell_stay [MAX_THREADS];
   logic [ID_BITS-1:0]    cell_id   [MAX_THREADS];
   logic [COUNT_BITS-1:0] cell_cnt  [MAX_THREADS];

   logic                  head_occ;
   logic [COUNT_BITS-1:0] tick_cnt;
   logic                  full;

   assign busy       = pend_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign head_occ = (size_ff != '0);
   // elapsed count saturates at all ones
   assign tick_cnt = (run_count_ff == COUNT_MAX) ? run_count_ff
                                                 : run_count_ff + COUNT_BITS'(1);

   // Each cell compares against the broadcast count and picks from itself or a
   // neighbor; cell 0 sees an always-staying left edge, the last cell an empty right.
   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      logic                  l_stay, r_stay;
      logic [ID_BITS-1:0]    l_id, r_id;
      logic [COUNT_BITS-1:0] l_cnt, r_cnt;
      logic                  occ;

      assign occ = (SIZE_BITS'(i) < size_ff);

      if (i == 0) begin : g_left_edge
         assign l_stay = 1'b1;
         assign l_id   = '0;
         assign l_cnt  = '0;
      end else begin : g_left
         assign l_stay = cell_stay[i-1];
         assign l_id   = cell_id[i-1];
         assign l_cnt  = cell_cnt[i-1];
      end

      if (i == MAX_THREADS - 1) begin : g_right_edge
         assign r_stay = 1'b0;
         assign r_id   = '0;
         assign r_cnt  = '0;
      end else begin : g_right
         assign r_stay = cell_stay[i+1];
         assign r_id   = cell_id[i+1];
         assign r_cnt  = cell_cnt[i+1];
      end

      sefs_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .ins_cnt    (ins_cnt),
         .occ        (occ),
         .left_stay  (l_stay),
         .left_id    (l_id),
         .left_cnt   (l_cnt),
         .right_stay (r_stay),
         .right_id   (r_id),
         .right_cnt  (r_cnt),
         .stay       (cell_stay[i]),
         .id         (cell_id[i]),
         .cnt        (cell_cnt[i])
      );
   end

   // Update cycle. Invariant: with no thread running the row is empty, so a create
   // while idle goes straight to the running slot.
   always_comb begin
      pend_in       = pend_ff;
      cmd_in        = cmd_ff;
      run_valid_in  = run_valid_ff;
      run_id_in     = run_id_ff;
      run_count_in  = run_count_ff;
      size_in       = size_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      ctl.mode      = CELL_HOLD;
      ctl.ins_id    = cmd_ff.thread_id;
      ins_cnt       = '0;
      full          = 1'b0;

      if (pend_ff) begin
         pend_in = 1'b0;
         case (cmd_ff.opcode)
            OP_CREATE: begin
               if (size_ff == SIZE_FULL) begin
                  full = 1'b1;
               end else if (!run_valid_ff) begin
                  run_valid_in = 1'b1;
                  run_id_in    = cmd_ff.thread_id;
                  run_count_in = '0;
               end else begin
                  ctl.mode = CELL_INSERT;
                  size_in  = size_ff + SIZE_BITS'(1);
               end
            end
            OP_TICK: begin
               ctl.ins_id = run_id_ff;
               ins_cnt    = tick_cnt;
               if (run_valid_ff) begin
                  if (head_occ && (cell_cnt[0] <= tick_cnt)) begin
                     // head takes over, old runner requeued behind its peers
                     ctl.mode     = CELL_POP_INSERT;
                     run_id_in    = cell_id[0];
                     run_count_in = cell_cnt[0];
                  end else begin
                     run_count_in = tick_cnt;
                  end
               end
            end
            OP_EXIT: begin
               if (run_valid_ff) begin
                  if (head_occ) begin
                     ctl.mode     = CELL_POP;
                     run_id_in    = cell_id[0];
                     run_count_in = cell_cnt[0];
                     size_in      = size_ff - SIZE_BITS'(1);
                  end else begin
                     run_valid_in = 1'b0;
                     run_id_in    = '0;
                     run_count_in = '0;
                  end
               end
            end
            default: begin
               ctl.mode = CELL_HOLD;
            end
         endcase
         rsp_strobe_in        = 1'b1;
         rsp_in.running_id    = run_valid_in ? run_id_in : '0;
         rsp_in.running_valid = run_valid_in;
         rsp_in.queue_full    = full;
      end else if (start) begin
         pend_in = 1'b1;
         cmd_in  = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff       <= 1'b0;
         run_valid_ff  <= 1'b0;
         run_id_ff     <= '0;
         run_count_ff  <= '0;
         size_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         pend_ff       <= pend_in;
         run_valid_ff  <= run_valid_in;
         run_id_ff     <= run_id_in;
         run_count_ff  <= run_count_in;
         size_ff       <= size_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   // Every executed command produces exactly one result the next cycle
   a_pend_strobe: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> rsp_strobe_ff)
      else $error("update cycle without result");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> !pend_ff)
      else $error("result overlaps a pending command");

   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      size_ff <= SIZE_FULL)
      else $error("ready row overflow");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !run_valid_ff |-> (size_ff == '0))
      else $error("queued threads while idle");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_ff.queue_full) |-> ($past(size_ff) == SIZE_FULL))
      else $error("queue_full without full row");

endmodule

[src/sefs_cell.sv]
module sefs_cell import sefs_pkg::*; #(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  cell_ctl_type          ctl,
   input  logic [COUNT_BITS-1:0] ins_cnt,
   input  logic                  occ,
   input  logic                  left_stay,
   input  logic [ID_BITS-1:0]    left_id,
   input  logic [COUNT_BITS-1:0] left_cnt,
   input  logic                  right_stay,
   input  logic [ID_BITS-1:0]    right_id,
   input  logic [COUNT_BITS-1:0] right_cnt,
   output logic                  stay,
   output logic [ID_BITS-1:0]    id,
   output logic [COUNT_BITS-1:0] cnt
);

   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;

   // Entry stays ahead of the new item when its count is not greater
   assign stay = occ && (cnt_ff <= ins_cnt);
   assign id   = id_ff;
   assign cnt  = cnt_ff;

   always_comb begin
      id_in  = id_ff;
      cnt_in = cnt_ff;
      case (ctl.mode)
         CELL_HOLD: begin
            id_in  = id_ff;
            cnt_in = cnt_ff;
         end
         CELL_INSERT: begin
            if (stay) begin
               id_in  = id_ff;
               cnt_in = cnt_ff;
            end else if (left_stay) begin
               id_in  = ctl.ins_id;
               cnt_in = ins_cnt;
            end else begin
               id_in  = left_id;
               cnt_in = left_cnt;
            end
         end
         CELL_POP: begin
            id_in  = right_id;
            cnt_in = right_cnt;
         end
         CELL_POP_INSERT: begin
            // row shifts toward the head, new item lands behind its peers
            if (right_stay) begin
               id_in  = right_id;
               cnt_in = right_cnt;
            end else if (stay) begin
               id_in  = ctl.ins_id;
               cnt_in = ins_cnt;
            end else begin
               id_in  = id_ff;
               cnt_in = cnt_ff;
            end
         end
         default: begin
            id_in  = id_ff;
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      cnt_ff <= cnt_in;
   end

endmodule

[sim/tb_top.sv]
module tb_top;
   import sefs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS = MAX_THREADS_DEF;
   localparam int CNT_W     = COUNT_BITS_DEF;
   localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

   // Opcode three has no package name; the block treats it as a no-op.
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam int RAND_ITEMS = 600;
   // Back-to-back ticks on a lone thread.
   localparam int LONE_TICKS = 16;
   // Well above the slowest legal run (every item behind the longest idle gap).
   localparam longint TIMEOUT_NS = 64'd500_000;

   // Command mix used by the random part: leans toward filling the ready
   // queue, toward draining it, or neither.
   typedef enum logic [1:0] {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   // One row of the directed table; has_fixed marks rows whose result is
   // typed in by hand instead of taken from the scheduler model below.
   typedef struct packed {
      req_type cmd;
      logic    has_fixed;
      rsp_type fixed_rsp;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;

   shortest_elapsed_first_scheduler #(
      .MAX_THREADS(NUM_SLOTS),
      .COUNT_BITS (CNT_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Scheduler model: ready queue sorted by elapsed count, ties in arrival
   // order, plus the running slot.
   // ---------------------------------------------------------------------
   logic [ID_BITS-1:0] ready_id  [NUM_SLOTS];
   logic [CNT_W-1:0]   ready_cnt [NUM_SLOTS];
   int                 ready_len;
   logic [ID_BITS-1:0] cur_id;
   logic [CNT_W-1:0]   cur_cnt;
   bit                 cur_on;

   // Expected results, oldest first.
   rsp_type sched_out[$];

   int      fail_count;
   bit      idle_on;
   rsp_type want_rsp;

   // Sorted insert; an equal count lands behind the ones already queued.
   function automatic void ready_insert(logic [ID_BITS-1:0] id, logic [CNT_W-1:0] cnt);
      int pos;
      pos = 0;
      while (pos < ready_len && ready_cnt[pos] <= cnt)
         pos++;
      for (int k = ready_len; k > pos; k--) begin
         ready_id[k]  = ready_id[k-1];
         ready_cnt[k] = ready_cnt[k-1];
      end
      ready_id[pos]  = id;
      ready_cnt[pos] = cnt;
      ready_len++;
   endfunction

   function automatic void ready_to_run();
      cur_id  = ready_id[0];
      cur_cnt = ready_cnt[0];
      cur_on  = 1'b1;
      for (int k = 1; k < ready_len; k++) begin
         ready_id[k-1]  = ready_id[k];
         ready_cnt[k-1] = ready_cnt[k];
      end
      ready_len--;
   endfunction

   function automatic rsp_type sched_step(req_type cmd);
      rsp_type            res;
      logic [ID_BITS-1:0] prev_id;
      logic [CNT_W-1:0]   prev_cnt;
      res = '0;
      case (cmd.opcode)
         OP_CREATE: begin
            if (ready_len >= NUM_SLOTS)
               res.queue_full = 1'b1;
            else
               ready_insert(cmd.thread_id, '0);
         end
         OP_TICK: begin
            if (cur_on) begin
               if (cur_cnt != CNT_TOP)
                  cur_cnt = cur_cnt + CNT_W'(1);
               // Yield only when the head has not run longer than we have.
               if (ready_len > 0 && ready_cnt[0] <= cur_cnt) begin
                  prev_id  = cur_id;
                  prev_cnt = cur_cnt;
                  // pop first so a full queue has room for the requeue
                  ready_to_run();
                  ready_insert(prev_id, prev_cnt);
               end
            end
         end
         OP_EXIT: begin
            if (cur_on) begin
               cur_on  = 1'b0;
               cur_id  = '0;
               cur_cnt = '0;
            end
         end
         default: ;
      endcase
      if (!cur_on && ready_len > 0)
         ready_to_run();
      res.running_id    = cur_on ? cur_id : '0;
      res.running_valid = cur_on;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Command side. Entered and left at a falling edge; the item is taken
   // at the first rising edge with busy low, and the model steps right then.
   // ---------------------------------------------------------------------
   task automatic send_item(input req_type cmd, input bit has_fixed, input rsp_type fixed_rsp);
      int      gap;
      rsp_type predicted;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_data = cmd;
      do @(posedge clock); while (busy);
      predicted = sched_step(cmd);
      sched_out.push_back(has_fixed ? fixed_rsp : predicted);
      @(negedge clock);
   endtask

   function automatic req_type make_cmd(logic [1:0] op, logic [ID_BITS-1:0] id);
      req_type c;
      c.opcode    = op;
      c.thread_id = id;
      return c;
   endfunction

   function automatic logic [ID_BITS-1:0] rand_id();
      return ID_BITS'($urandom_range(0, 15));
   endfunction

   function automatic logic [1:0] pick_op(mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  return roll < 60 ? OP_CREATE : roll < 85 ? OP_TICK :
                           roll < 95 ? OP_EXIT : OP_NOP;
         MIX_DRAIN: return roll < 15 ? OP_CREATE : roll < 50 ? OP_TICK :
                           roll < 95 ? OP_EXIT : OP_NOP;
         default:   return roll < 35 ? OP_CREATE : roll < 70 ? OP_TICK :
                           roll < 95 ? OP_EXIT : OP_NOP;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result side: the block cannot be stalled, so just check every strobe.
   // ---------------------------------------------------------------------
   task automatic report_field(string field, int exp_val, int act_val);
      fail_count++;
      if (fail_count <= 10)
         $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field, exp_val, act_val);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (sched_out.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("mismatch at %0t: result with nothing outstanding (id %0d valid %0d)",
                        $realtime, rsp_data.running_id, rsp_data.running_valid);
         end else begin
            want_rsp = sched_out.pop_front();
            if (rsp_data.running_id !== want_rsp.running_id)
               report_field("running_id", int'(want_rsp.running_id),
                            int'(rsp_data.running_id));
            if (rsp_data.running_valid !== want_rsp.running_valid)
               report_field("running_valid", int'(want_rsp.running_valid),
                            int'(rsp_data.running_valid));
            if (rsp_data.queue_full !== want_rsp.queue_full)
               report_field("queue_full", int'(want_rsp.queue_full),
                            int'(rsp_data.queue_full));
         end
      end
   end

   // Directed items. Row notes:
   //  idle ticks / exits / no-op change nothing
   //  a create while running does not preempt
   //  ticks hand over on equal-or-lower head count
   //  16 creates (one with the running thread's id) fill the queue, the next is refused
   localparam int DIR_LEN = 25;
   localparam dir_row_type DIR_TBL [DIR_LEN] = '{
      '{'{OP_TICK,   4'd9},  1'b1, '{4'd0,  1'b0, 1'b0}},
      '{'{OP_EXIT,   4'd6},  1'b1, '{4'd0,  1'b0, 1'b0}},
      '{'{OP_NOP,    4'd15}, 1'b1, '{4'd0,  1'b0, 1'b0}},
      '{'{OP_CREATE, 4'd15}, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd0},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_TICK,   4'd3},  1'b0, '0},
      '{'{OP_EXIT,   4'd12}, 1'b0, '0},
      '{'{OP_CREATE, 4'd0},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd1},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd2},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd3},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd4},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd5},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd6},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd7},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd8},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd9},  1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd10}, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd11}, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd12}, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd13}, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd14}, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd15}, 1'b1, '{4'd15, 1'b1, 1'b0}},
      '{'{OP_CREATE, 4'd7},  1'b1, '{4'd15, 1'b1, 1'b1}},
      '{'{OP_TICK,   4'd0},  1'b0, '0}
   };

   initial begin
      int      wait_cycles;
      mix_type mix;
      clock      = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      fail_count = 0;
      idle_on    = 1'b1;
      ready_len  = 0;
      cur_id     = '0;
      cur_cnt    = '0;
      cur_on     = 1'b0;
      mix        = MIX_EVEN;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < DIR_LEN; i++)
         send_item(DIR_TBL[i].cmd, DIR_TBL[i].has_fixed, DIR_TBL[i].fixed_rsp);

      // Random part: mix and idling redrawn every 40 items so the queue
      // swings between full and empty, with some back-to-back stretches.
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if (i % 40 == 0) begin
            mix     = mix_type'($urandom_range(0, 2));
            idle_on = $urandom_range(0, 3) != 0;
         end
         send_item(make_cmd(pick_op(mix), rand_id()), 1'b0, '0);
      end

      // Lone thread: empty the scheduler, then tick one thread back to back.
      idle_on = 1'b0;
      while (cur_on)
         send_item(make_cmd(OP_EXIT, rand_id()), 1'b0, '0);
      send_item(make_cmd(OP_CREATE, rand_id()), 1'b0, '0);
      for (int i = 0; i < LONE_TICKS; i++)
         send_item(make_cmd(OP_TICK, rand_id()), 1'b0, '0);

      // Older thread yields to a newcomer, then resumes after its exit.
      idle_on = 1'b1;
      send_item(make_cmd(OP_CREATE, rand_id()), 1'b0, '0);
      send_item(make_cmd(OP_TICK,   rand_id()), 1'b0, '0);
      send_item(make_cmd(OP_TICK,   rand_id()), 1'b0, '0);
      send_item(make_cmd(OP_EXIT,   rand_id()), 1'b0, '0);
      send_item(make_cmd(OP_TICK,   rand_id()), 1'b0, '0);
      start = 1'b0;

      // Drain: only the last result is still on its way, so a short bounded wait is plenty.
      wait_cycles = 0;
      while (sched_out.size() != 0 && wait_cycles < 100) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (5) @(posedge clock);
      if (sched_out.size() != 0) begin
         fail_count++;
         $display("%0d results never arrived", sched_out.size());
      end

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d results outstanding", sched_out.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
